@@ rtl/core/tric_pkg.sv @@
// Shared constants, types and the word population count for the triangle counter.
package tric_pkg;

    localparam int WORD_W        = 32;
    localparam int LOG_W         = 5;
    localparam int ACC_W         = 32;
    localparam int TOTAL_W       = 19;
    localparam int DEF_MAX_NODES = 128;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_COUNT = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_acc_ctrl;

    function automatic logic [LOG_W:0] popcount(input logic [WORD_W-1:0] v);
        logic [LOG_W:0] s [WORD_W];
        for (int b = 0; b < WORD_W; b++) begin
            s[b] = {{LOG_W{1'b0}}, v[b]};
        end
        for (int l = 0; l < LOG_W; l++) begin
            for (int p = 0; p < (WORD_W >> (l + 1)); p++) begin
                s[p] = s[2 * p] + s[2 * p + 1];
            end
        end
        return s[0];
    endfunction

endpackage

@@ rtl/core/triangle_counter.sv @@
// Triangle counter over an adjacency bit matrix held in one synchronous memory.
// An edge write does not make the block busy, and writes follow each other back to back. A count
// with node count n (clamped to MAX_NODES) walks rows i from 0 to n-3: for each row it loads
// row i from the memory word by word, passes a turnaround state, and then for every j from
// i+1 to n-2 either moves on when bit (i,j) is clear, or reads each 32-bit word from the word
// holding j to the word holding n-1 when it is set. A drain state then waits for the
// accumulator to empty, and the total is registered out after it; a count with fewer than
// three nodes goes straight to the drain state. The single read port of the adjacency
// memory sets the pace of this walk. The memory has no clearing pass; every pair below n must be
// written before a count. The total is shown for exactly one cycle with o_result_strobe,
// and busy stays high from the transfer of a count until that cycle, so the receiver
// cannot stall.
module triangle_counter #(
    parameter int MAX_NODES = tric_pkg::DEF_MAX_NODES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic [$clog2(MAX_NODES)-1:0]        i_row_node,
    input  logic [$clog2(MAX_NODES)-1:0]        i_col_node,
    input  logic                                i_edge_present,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [$clog2(MAX_NODES+1)-1:0]      i_node_count,
    output logic                                o_result_strobe,
    output logic [tric_pkg::TOTAL_W-1:0]        o_triangle_total
);

    localparam int W      = tric_pkg::WORD_W;
    localparam int LW     = tric_pkg::LOG_W;
    localparam int NW     = $clog2(MAX_NODES);
    localparam int NCW    = $clog2(MAX_NODES + 1);
    localparam int CHUNKS = (MAX_NODES + W - 1) / W;
    localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int KW     = CHW + LW;
    localparam int DEPTH  = MAX_NODES * CHUNKS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_GAP,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state                        r_state;
    logic [NCW-1:0]                r_node_count;
    logic [NW-1:0]                 r_i;
    logic [NW-1:0]                 r_j;
    logic [NW-1:0]                 r_last;
    logic [CHW-1:0]                r_c;
    logic                          r_p1_load;
    logic                          r_p1_acc;
    logic [CHW-1:0]                r_p1_chunk;
    logic [W-1:0]                  r_p1_mask;
    logic [CHUNKS*W-1:0]           r_row_i;
    logic [W-1:0]                  r_mem [DEPTH];
    logic [W-1:0]                  r_rd_data;
    logic                          r_out_valid;
    logic [tric_pkg::TOTAL_W-1:0]  r_total;

    logic                          take_write;
    logic                          take_count;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [LW-1:0]                 wr_bit;
    logic [AW-1:0]                 rd_addr;
    logic [NCW-1:0]                n_eff;
    logic [W-1:0]                  mask;
    logic [CHW-1:0]                last_chunk;
    logic [NW-1:0]                 j_next;
    logic                          row_done;
    logic                          all_done;
    logic                          edge_ij;
    tric_pkg::t_acc_ctrl           acc_ctrl;
    logic [tric_pkg::ACC_W-1:0]    acc_total;
    logic                          acc_pending;

    assign take_write = start && !busy && (i_operation == tric_pkg::OP_WRITE);
    assign take_count = start && !busy && (i_operation == tric_pkg::OP_COUNT);

    assign wr_en   = take_write && (i_row_node < i_col_node)
                     && ((NW + 1)'(i_col_node) < (NW + 1)'(MAX_NODES));
    assign wr_addr = AW'(AW'(i_row_node) * AW'(CHUNKS)) + AW'(CHW'(i_col_node >> LW));
    assign wr_bit  = LW'(i_col_node);

    assign rd_addr = (r_state == S_SCAN)
                     ? AW'(AW'(r_j) * AW'(CHUNKS)) + AW'(r_c)
                     : AW'(AW'(r_i) * AW'(CHUNKS)) + AW'(r_c);

    assign n_eff      = (r_node_count > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : r_node_count;
    assign last_chunk = CHW'(r_last >> LW);
    assign j_next     = r_j + NW'(1);
    assign row_done   = (j_next == r_last);
    assign all_done   = ((r_i + NW'(1)) == (r_last - NW'(1)));
    assign edge_ij    = r_row_i[r_j];

    always_comb begin
        logic [KW-1:0] k;
        for (int b = 0; b < W; b++) begin
            k       = {r_c, LW'(b)};
            mask[b] = (k > KW'(r_j)) && (k <= KW'(r_last));
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr][wr_bit] <= i_edge_present;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_load) begin
            r_row_i[r_p1_chunk*W +: W] <= r_rd_data;
        end
        r_p1_chunk <= r_c;
        r_p1_mask  <= mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NCW'(MAX_NODES);
            r_i          <= '0;
            r_j          <= '0;
            r_last       <= '0;
            r_c          <= '0;
            r_p1_load    <= 1'b0;
            r_p1_acc     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_p1_load   <= 1'b0;
            r_p1_acc    <= 1'b0;
            r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_node_count;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take_count) begin
                        r_i    <= '0;
                        r_c    <= '0;
                        r_last <= NW'(n_eff - NCW'(1));
                        if (n_eff < NCW'(3)) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_p1_load <= 1'b1;
                    if (r_c == CHW'(CHUNKS - 1)) begin
                        r_j     <= r_i + NW'(1);
                        r_c     <= CHW'((r_i + NW'(1)) >> LW);
                        r_state <= S_GAP;
                    end else begin
                        r_c <= r_c + CHW'(1);
                    end
                end
                S_GAP: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (edge_ij) begin
                        r_p1_acc <= 1'b1;
                    end
                    if (edge_ij && (r_c != last_chunk)) begin
                        r_c <= r_c + CHW'(1);
                    end else if (!row_done) begin
                        r_j <= j_next;
                        r_c <= CHW'(j_next >> LW);
                    end else if (all_done) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_i     <= r_i + NW'(1);
                        r_c     <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_acc && !acc_pending) begin
                        r_out_valid <= 1'b1;
                        r_total     <= (acc_total > tric_pkg::ACC_W'(tric_pkg::TOTAL_MAX))
                                       ? tric_pkg::TOTAL_MAX
                                       : acc_total[tric_pkg::TOTAL_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign acc_ctrl.clear = take_count;
    assign acc_ctrl.valid = r_p1_acc;

    tric_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (acc_ctrl),
        .i_data    (r_rd_data),
        .i_row     (r_row_i[r_p1_chunk*W +: W]),
        .i_mask    (r_p1_mask),
        .o_total   (acc_total),
        .o_pending (acc_pending)
    );

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = !busy;
    assign o_result_strobe  = r_out_valid;
    assign o_triangle_total = r_total;

endmodule

@@ rtl/core/tric_accum.sv @@
// Masked row intersection and population count accumulator of the triangle counter.
module tric_accum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tric_pkg::t_acc_ctrl               i_ctrl,
    input  logic [tric_pkg::WORD_W-1:0]       i_data,
    input  logic [tric_pkg::WORD_W-1:0]       i_row,
    input  logic [tric_pkg::WORD_W-1:0]       i_mask,
    output logic [tric_pkg::ACC_W-1:0]        o_total,
    output logic                              o_pending
);

    logic                          r_valid;
    logic [tric_pkg::WORD_W-1:0]   r_and;
    logic [tric_pkg::ACC_W-1:0]    r_acc;

    always_ff @(posedge i_clk) begin
        r_and <= i_data & i_row & i_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_valid <= i_ctrl.valid;
            if (i_ctrl.clear) begin
                r_acc <= '0;
            end else if (r_valid) begin
                r_acc <= r_acc + tric_pkg::ACC_W'(tric_pkg::popcount(r_and));
            end
        end
    end

    assign o_total   = r_acc;
    assign o_pending = r_valid;

endmodule

@@ rtl/core/tric_checker.sv @@
// Port-level checker for the triangle counter and the bind that attaches it.
module tric_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_operation,
    input logic o_result_strobe
);

    property p_strobe_single;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_result_strobe |=> !o_result_strobe;
    endproperty

    property p_write_stays_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
            (start && !busy && (i_operation == tric_pkg::OP_WRITE)) |=> !busy;
    endproperty

    property p_count_goes_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            (start && !busy && (i_operation == tric_pkg::OP_COUNT)) |=> busy;
    endproperty

    property p_strobe_ends_count;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_result_strobe |-> (!busy && $past(busy));
    endproperty

    a_strobe_single: assert property (p_strobe_single)
        else $error("Result strobe was high for more than one cycle.");
    a_write_stays_idle: assert property (p_write_stays_idle)
        else $error("An edge write transfer made the block busy.");
    a_count_goes_busy: assert property (p_count_goes_busy)
        else $error("A count transfer did not make the block busy.");
    a_strobe_ends_count: assert property (p_strobe_ends_count)
        else $error("A result appeared without a count in progress.");

endmodule

bind triangle_counter tric_checker u_tric_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_operation     (i_operation),
    .o_result_strobe (o_result_strobe)
);
